// File: rtl/smeu_pkg.sv
// Package for the stack machine execute unit: opcodes, status codes, sizes.
// No dependencies.
package smeu_pkg;
    localparam int StackDepth   = 4096;
    localparam int ProgramDepth = 1024;
    localparam int SpW          = $clog2(StackDepth);
    localparam int DepthW       = 13;
    localparam int PcW          = 11;

    localparam logic [3:0] OP_NOP    = 4'd0;
    localparam logic [3:0] OP_PUSH   = 4'd1;
    localparam logic [3:0] OP_DROP   = 4'd2;
    localparam logic [3:0] OP_JMP    = 4'd3;
    localparam logic [3:0] OP_JMPIF  = 4'd4;
    localparam logic [3:0] OP_DUP    = 4'd5;
    localparam logic [3:0] OP_SWAP   = 4'd6;
    localparam logic [3:0] OP_EQ     = 4'd7;
    localparam logic [3:0] OP_CLEAR  = 4'd8;
    localparam logic [3:0] OP_ADD    = 4'd9;
    localparam logic [3:0] OP_SUB    = 4'd10;
    localparam logic [3:0] OP_MUL    = 4'd11;
    localparam logic [3:0] OP_DIV    = 4'd12;
    localparam logic [3:0] OP_PRINT  = 4'd13;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_OVER  = 3'd1;
    localparam logic [2:0] ST_UNDER = 3'd2;
    localparam logic [2:0] ST_ERR   = 3'd3;
    localparam logic [2:0] ST_UNDEF = 3'd4;
    localparam logic [2:0] ST_HALT  = 3'd5;

    typedef struct packed {
        logic start;
        logic is_mul;
    } t_alu_cmd;
endpackage

// File: rtl/smeu_muldiv.sv
// Shared iterative multiply / unsigned divide unit, one bit per cycle.
// Depends on smeu_pkg.
module smeu_muldiv (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  smeu_pkg::t_alu_cmd  i_cmd,
    input  logic [63:0]         i_a,
    input  logic [63:0]         i_b,
    output logic                o_done,
    output logic [63:0]         o_result
);
    logic        r_busy, n_busy;
    logic        r_mul, n_mul;
    logic [6:0]  r_cnt, n_cnt;
    logic [63:0] r_acc, n_acc;
    logic [63:0] r_a, n_a;
    logic [63:0] r_b, n_b;
    logic [64:0] w_trial;

    // mul: r_acc sums, r_a shifts left, r_b shifts right
    // div: r_a quotient/dividend shifting left, r_acc remainder, r_b divisor
    always_comb begin
        n_busy  = r_busy;
        n_mul   = r_mul;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_a     = r_a;
        n_b     = r_b;
        w_trial = {r_acc[63:0], r_a[63]} - {1'b0, r_b};
        if (i_cmd.start) begin
            n_busy = 1'b1;
            n_mul  = i_cmd.is_mul;
            n_cnt  = 7'd0;
            n_acc  = '0;
            n_a    = i_a;
            n_b    = i_b;
        end else if (r_busy) begin
            if (r_mul) begin
                if (r_b[0]) n_acc = r_acc + r_a;
                n_a = {r_a[62:0], 1'b0};
                n_b = {1'b0, r_b[63:1]};
            end else if (!w_trial[64]) begin
                n_acc = w_trial[63:0];
                n_a   = {r_a[62:0], 1'b1};
            end else begin
                n_acc = {r_acc[62:0], r_a[63]};
                n_a   = {r_a[62:0], 1'b0};
            end
            n_cnt = r_cnt + 7'd1;
            if (r_cnt == 7'd63) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_mul <= n_mul;
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
    end

    assign o_done   = r_busy && (r_cnt == 7'd63);
    assign o_result = r_mul ? n_acc : n_a;
endmodule

// File: rtl/stack_machine_execute_unit.sv
// Stack machine execute unit: top level with stack memory and sequencer.
// Depends on smeu_pkg and smeu_muldiv.
//
// Usage: one instruction beat on the input channel (operation, immediate,
// jump_target) yields exactly one result beat (status, next_pc, print_valid,
// print_value, stack_count). program_length is written on its own channel;
// the user must write it only while the block is idle; the block itself
// does not enforce this. Each instruction goes idle (accept, read of the top
// entry), RD1 (top arrives, read of the second), EXEC, then OUT. A successful
// swap, add or sub goes through WR2 before OUT (swap writes its second entry,
// add and sub their result); a successful mul or div goes through ALU, which
// starts the shared one-bit-per-cycle multiply/divide unit and waits for it,
// then WR2. The input is not ready while an item is in flight or its result
// waits, so the next beat is taken in the cycle after the result beat. The
// single stack memory port (one read and one write per cycle) forces RD1.
// Reset clears depth, pc, halt flag and program_length; stack contents are
// not cleared, and entries not yet written are never used.
// A stalled receiver holds the result in the output register; the next
// item is taken once the result beat completes.
module stack_machine_execute_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [3:0]   i_operation,
    input  logic [63:0]  i_immediate,
    input  logic [10:0]  i_jump_target,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [10:0]  i_program_length,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [2:0]   o_status,
    output logic [10:0]  o_next_pc,
    output logic         o_print_valid,
    output logic [63:0]  o_print_value,
    output logic [12:0]  o_stack_count
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD1   = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd3;
    localparam logic [2:0] S_ALU   = 3'd4;
    localparam logic [2:0] S_WR2   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    localparam int SpW = smeu_pkg::SpW;

    logic [63:0] r_mem [smeu_pkg::StackDepth];
    logic [63:0] r_rdata;
    logic        mem_we;
    logic [SpW-1:0] mem_waddr, mem_raddr;
    logic [63:0] mem_wdata;

    logic [2:0]  r_state, n_state;
    logic [3:0]  r_op;
    logic [63:0] r_imm;
    logic [10:0] r_tgt;
    logic [10:0] r_plen;
    logic [12:0] r_depth, n_depth;
    logic [10:0] r_pc, n_pc;
    logic        r_halt, n_halt;
    logic [63:0] r_top, n_top;
    logic [63:0] r_sec, n_sec;
    logic        r_ovalid, n_ovalid;
    logic [2:0]  r_status, n_status;
    logic [10:0] r_opc, n_opc;
    logic        r_opv, n_opv;
    logic [63:0] r_oval, n_oval;
    logic [12:0] r_ocnt, n_ocnt;
    logic [63:0] r_wr2, n_wr2;
    logic        r_neg, n_neg;

    smeu_pkg::t_alu_cmd alu_cmd;
    logic        alu_done;
    logic [63:0] alu_res;
    logic [63:0] alu_a, alu_b;

    logic [10:0] eff_len, pc_inc;
    logic        full, lt1, lt2, tgt_bad;
    logic [63:0] abs_top, abs_sec;

    smeu_muldiv u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (alu_cmd),
        .i_a      (alu_a),
        .i_b      (alu_b),
        .o_done   (alu_done),
        .o_result (alu_res)
    );

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        r_rdata <= r_mem[mem_raddr];
    end

    assign eff_len = (r_plen > 11'(smeu_pkg::ProgramDepth))
                     ? 11'(smeu_pkg::ProgramDepth) : r_plen;
    assign pc_inc  = (r_pc < 11'(smeu_pkg::ProgramDepth)) ? r_pc + 11'd1 : r_pc;
    assign full    = r_depth >= 13'(smeu_pkg::StackDepth);
    assign lt1     = r_depth < 13'd1;
    assign lt2     = r_depth < 13'd2;
    assign tgt_bad = r_tgt > eff_len;
    assign abs_top = r_top[63] ? 64'(0) - r_top : r_top;
    assign abs_sec = r_sec[63] ? 64'(0) - r_sec : r_sec;

    always_comb begin
        n_state  = r_state;
        n_depth  = r_depth;
        n_pc     = r_pc;
        n_halt   = r_halt;
        n_top    = r_top;
        n_sec    = r_sec;
        n_ovalid = r_ovalid;
        n_status = r_status;
        n_opc    = r_opc;
        n_opv    = r_opv;
        n_oval   = r_oval;
        n_ocnt   = r_ocnt;
        n_wr2    = r_wr2;
        n_neg    = r_neg;
        mem_we    = 1'b0;
        mem_waddr = r_depth[SpW-1:0];
        mem_wdata = r_imm;
        mem_raddr = SpW'(r_depth - 13'd1);
        alu_cmd   = '0;
        alu_a     = r_top;
        alu_b     = r_sec;
        if (r_ovalid && i_ready) n_ovalid = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) n_state = S_RD1;
            end
            S_RD1: begin
                // top arrived from the idle-cycle read; fetch second now
                n_top     = r_rdata;
                mem_raddr = SpW'(r_depth - 13'd2);
                n_state   = S_EXEC;
            end
            S_EXEC: begin
                n_sec    = r_rdata;
                n_state  = S_OUT;
                n_status = smeu_pkg::ST_OK;
                n_opv    = 1'b0;
                n_oval   = '0;
                if (r_halt) begin
                    n_status = smeu_pkg::ST_HALT;
                end else begin
                    n_pc = pc_inc;
                    case (r_op)
                        smeu_pkg::OP_NOP: ;
                        smeu_pkg::OP_PUSH: begin
                            if (full) n_status = smeu_pkg::ST_OVER;
                            else begin
                                mem_we  = 1'b1;
                                n_depth = r_depth + 13'd1;
                            end
                        end
                        smeu_pkg::OP_DROP: begin
                            if (lt1) n_status = smeu_pkg::ST_UNDER;
                            else n_depth = r_depth - 13'd1;
                        end
                        smeu_pkg::OP_JMP: begin
                            if (tgt_bad) n_status = smeu_pkg::ST_ERR;
                            else n_pc = r_tgt;
                        end
                        smeu_pkg::OP_JMPIF: begin
                            if (lt1) n_status = smeu_pkg::ST_UNDER;
                            else if (r_top != r_imm) begin
                                if (tgt_bad) n_status = smeu_pkg::ST_ERR;
                                else n_pc = r_tgt;
                            end
                        end
                        smeu_pkg::OP_DUP: begin
                            if (lt1) n_status = smeu_pkg::ST_UNDER;
                            else if (full) n_status = smeu_pkg::ST_OVER;
                            else begin
                                mem_we    = 1'b1;
                                mem_wdata = r_top;
                                n_depth   = r_depth + 13'd1;
                            end
                        end
                        smeu_pkg::OP_SWAP: begin
                            if (lt2) n_status = smeu_pkg::ST_UNDER;
                            else begin
                                mem_we    = 1'b1;
                                mem_waddr = SpW'(r_depth - 13'd1);
                                mem_wdata = r_rdata;
                                n_wr2     = r_top;
                                n_state   = S_WR2;
                            end
                        end
                        smeu_pkg::OP_EQ: begin
                            if (lt2) n_status = smeu_pkg::ST_UNDER;
                            else if (full) n_status = smeu_pkg::ST_OVER;
                            else begin
                                mem_we    = 1'b1;
                                mem_wdata = {63'd0, r_top == r_rdata};
                                n_depth   = r_depth + 13'd1;
                            end
                        end
                        smeu_pkg::OP_CLEAR: n_depth = '0;
                        smeu_pkg::OP_ADD, smeu_pkg::OP_SUB: begin
                            if (lt2) n_status = smeu_pkg::ST_UNDER;
                            else begin
                                n_wr2   = (r_op == smeu_pkg::OP_ADD) ? r_top + r_rdata
                                                                     : r_rdata - r_top;
                                n_state = S_WR2;
                            end
                        end
                        smeu_pkg::OP_MUL, smeu_pkg::OP_DIV: begin
                            if (lt2) n_status = smeu_pkg::ST_UNDER;
                            else if (r_op == smeu_pkg::OP_DIV && r_rdata == '0)
                                n_status = smeu_pkg::ST_ERR;
                            else n_state = S_ALU;
                        end
                        smeu_pkg::OP_PRINT: begin
                            if (lt1) n_status = smeu_pkg::ST_UNDER;
                            else begin
                                n_opv  = 1'b1;
                                n_oval = r_top;
                            end
                        end
                        default: n_status = smeu_pkg::ST_UNDEF;
                    endcase
                    if (n_status != smeu_pkg::ST_OK) begin
                        mem_we  = 1'b0;
                        n_halt  = 1'b1;
                        n_pc    = r_pc;
                        n_depth = r_depth;
                        n_state = S_OUT;
                    end
                end
                if (n_state == S_ALU) begin
                    // r_sec is registered at the end of this state; S_ALU issues the start
                    n_neg = 1'b0;
                end
                n_opc = n_pc;
            end
            S_ALU: begin
                if (!r_neg) begin
                    alu_cmd.start  = 1'b1;
                    alu_cmd.is_mul = (r_op == smeu_pkg::OP_MUL);
                    alu_a = (r_op == smeu_pkg::OP_MUL) ? r_top : abs_top;
                    alu_b = (r_op == smeu_pkg::OP_MUL) ? r_sec : abs_sec;
                    n_neg = 1'b1;
                end else if (alu_done) begin
                    n_wr2 = (r_op == smeu_pkg::OP_DIV && (r_top[63] ^ r_sec[63]))
                            ? 64'(0) - alu_res : alu_res;
                    n_state = S_WR2;
                end
            end
            S_WR2: begin
                mem_we    = 1'b1;
                mem_waddr = SpW'(r_depth - 13'd2);
                mem_wdata = r_wr2;
                if (r_op != smeu_pkg::OP_SWAP) n_depth = r_depth - 13'd1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid) begin
                    n_ovalid = 1'b1;
                    n_ocnt   = r_depth;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_depth  <= '0;
            r_pc     <= '0;
            r_halt   <= 1'b0;
            r_ovalid <= 1'b0;
            r_plen   <= '0;
            r_neg    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_depth  <= n_depth;
            r_pc     <= n_pc;
            r_halt   <= n_halt;
            r_ovalid <= n_ovalid;
            r_neg    <= n_neg;
            if (i_cfg_valid) r_plen <= i_program_length;
        end
        if (i_valid && o_ready) begin
            r_op  <= i_operation;
            r_imm <= i_immediate;
            r_tgt <= i_jump_target;
        end
        r_top    <= n_top;
        r_sec    <= n_sec;
        r_status <= n_status;
        r_opc    <= n_opc;
        r_opv    <= n_opv;
        r_oval   <= n_oval;
        r_ocnt   <= n_ocnt;
        r_wr2    <= n_wr2;
    end

    assign o_ready       = (r_state == S_IDLE) && !r_ovalid;
    assign o_cfg_ready   = 1'b1;
    assign o_valid       = r_ovalid;
    assign o_status      = r_status;
    assign o_next_pc     = r_opc;
    assign o_print_valid = r_opv;
    assign o_print_value = r_oval;
    assign o_stack_count = r_ocnt;
endmodule

// File: rtl/smeu_checker.sv
// Port-level checker for the stack machine execute unit, bound to the top.
// Depends on smeu_pkg and the stack_machine_execute_unit ports.
module smeu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_status,
    input logic        o_print_valid,
    input logic [63:0] o_print_value
);
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready) else $error("ready right after accept");
    a_no_ready_with_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("ready while result pending");
    a_print_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_print_valid |-> o_status == smeu_pkg::ST_OK)
        else $error("print with error");
    a_print_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_print_valid |-> o_print_value == '0) else $error("stray print value");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status)) else $error("result dropped");
endmodule

bind stack_machine_execute_unit smeu_checker u_smeu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_status      (o_status),
    .o_print_valid (o_print_valid),
    .o_print_value (o_print_value)
);
